@@ rtl/tqls_pkg.sv @@
`default_nettype none

package tqls_pkg;

  localparam int NUM_STATES  = 8;
  localparam int NUM_ACTIONS = 8;
  localparam int TABLE_DEPTH = NUM_STATES * NUM_ACTIONS;

  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int ACT_W   = $clog2(NUM_ACTIONS);
  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int J_W     = $clog2(NUM_ACTIONS + 1);

  localparam int Q_W      = 32;
  localparam int FRAC_W   = 16;
  localparam int RATE_W   = 16;
  localparam int MARK_W   = 32;
  localparam int REWARD_W = 3;
  localparam int ACT_FIELD_W = 3;
  localparam int DELTA_W  = 35;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE   = 2'd0,
    CFG_DISCOUNT     = 2'd1,
    CFG_INIT_LOW     = 2'd2,
    CFG_INIT_HIGH    = 2'd3
  } cfg_idx_t;

  localparam logic [RATE_W-1:0] LEARN_RATE_RST = 16'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_RST   = 16'd58982;

  localparam logic signed [REWARD_W-1:0] REWARD_GOOD = 3'sd2;
  localparam logic signed [REWARD_W-1:0] REWARD_NONE = 3'sd0;
  localparam logic signed [REWARD_W-1:0] REWARD_BAD  = -3'sd2;

  typedef struct packed {
    logic                       valid;
    logic signed [REWARD_W-1:0] reward;
    logic signed [Q_W-1:0]      qval;
    logic signed [Q_W-1:0]      qbest;
    logic [RATE_W-1:0]          gamma;
    logic [RATE_W-1:0]          alpha;
  } upd_req_t;

  typedef struct packed {
    logic                  valid;
    logic signed [Q_W-1:0] qnew;
  } upd_rsp_t;

endpackage

`default_nettype wire

@@ rtl/tqls_ram.sv @@
`default_nettype none

module tqls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/tqls_update.sv @@
`default_nettype none

module tqls_update
  import tqls_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire upd_req_t req,
  output upd_rsp_t      rsp
);

  localparam int P1_W  = RATE_W + 1 + Q_W;
  localparam int P3_W  = RATE_W + 1 + DELTA_W;
  localparam int SUM_W = P3_W - FRAC_W + 1;

  logic v1_r, v2_r, v3_r;

  logic signed [P1_W-1:0]     p1_r;
  logic signed [REWARD_W-1:0] rw1_r;
  logic signed [Q_W-1:0]      qv1_r, qv2_r, qv3_r;
  logic [RATE_W-1:0]          a1_r, a2_r;
  logic signed [DELTA_W-1:0]  d2_r;
  logic signed [P3_W-1:0]     p3_r;

  logic signed [SUM_W-1:0]    sum;
  logic                       ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // gamma * rowmax, then delta, then alpha * delta
  always_ff @(posedge clk) begin
    p1_r  <= $signed({1'b0, req.gamma}) * req.qbest;
    rw1_r <= req.reward;
    qv1_r <= req.qval;
    a1_r  <= req.alpha;

    d2_r  <= (DELTA_W'(rw1_r) <<< FRAC_W) + DELTA_W'(p1_r >>> FRAC_W) - DELTA_W'(qv1_r);
    qv2_r <= qv1_r;
    a2_r  <= a1_r;

    p3_r  <= $signed({1'b0, a2_r}) * d2_r;
    qv3_r <= qv2_r;
  end

  always_comb begin
    sum = SUM_W'(qv3_r) + SUM_W'(p3_r >>> FRAC_W);
    ovf = (sum[SUM_W-1:Q_W-1] != '0) && (sum[SUM_W-1:Q_W-1] != '1);
    rsp.valid = v3_r;
    if (ovf) begin
      rsp.qnew = sum[SUM_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end else begin
      rsp.qnew = sum[Q_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/tabular_q_learner_step.sv @@
// One item in flight at a time (in_tready only in idle); the row walk reads the Q table one
//   entry per cycle through its single read port, then a three-stage multiply pipeline.
// Reset (rst_n low, synchronous): Q table reads as zero via per-entry valid bits,
//   marks, states and config registers return to their defaults, output empties.
`default_nettype none

module tabular_q_learner_step
  import tqls_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // timestep[31:0], exec_time[63:32]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // chosen_action[2:0], reward_code[5:3], pad
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LAUNCH,
    ST_UPD,
    ST_WRITE
  } state_t;

  state_t state_r;

  logic [RATE_W-1:0] learn_rate_r, discount_r;
  logic [MARK_W-1:0] init_low_r, init_high_r;
  logic [MARK_W-1:0] low_r, high_r;
  logic [STATE_W-1:0] trial_r, cur_r, row_r;

  logic                       explore_r;
  logic [ACT_W-1:0]           action_r;
  logic signed [REWARD_W-1:0] reward_r;
  logic [J_W-1:0]             j_r;
  logic                       pend_r;
  logic [ACT_W-1:0]           pj_r;
  logic signed [Q_W-1:0]      best_val_r, qval_r, qnew_r;
  logic [ACT_W-1:0]           best_idx_r;

  logic [TABLE_DEPTH-1:0]     tbl_valid_r;
  logic                       rd_valid_r;

  logic                       out_valid_r;
  logic [ACT_FIELD_W-1:0]     out_action_r;
  logic signed [REWARD_W-1:0] out_reward_r;

  // accept-time decode
  logic [Q_W-1:0]             in_timestep, in_exec;
  logic                       explore;
  logic [ACT_W-1:0]           t_act;
  logic [STATE_W-1:0]         trial_acc, row_acc;
  logic [MARK_W-1:0]          low_nxt, high_nxt;
  logic signed [REWARD_W-1:0] reward_nxt;

  logic [ADDR_W-1:0]     ram_raddr, ram_waddr;
  logic [Q_W-1:0]        ram_rdata;
  logic                  ram_we;
  logic signed [Q_W-1:0] rd_q;
  logic                  out_free;

  upd_req_t upd_req;
  upd_rsp_t upd_rsp;

  always_comb begin
    in_timestep = in_tdata[Q_W-1:0];
    in_exec     = in_tdata[2*Q_W-1:Q_W];
    explore     = in_timestep < Q_W'(TABLE_DEPTH);
    t_act       = ACT_W'(in_timestep % NUM_ACTIONS);

    trial_acc = trial_r;
    if (explore && (t_act == '0)) begin
      if (in_timestep == '0) begin
        trial_acc = '0;
      end else if (trial_r == STATE_W'(NUM_STATES - 1)) begin
        trial_acc = '0;
      end else begin
        trial_acc = trial_r + 1'b1;
      end
    end
    row_acc = explore ? trial_acc : cur_r;

    // marks are updated in order, each test sees the previous one's result
    low_nxt    = (in_timestep == '0) ? init_low_r  : low_r;
    high_nxt   = (in_timestep == '0) ? init_high_r : high_r;
    reward_nxt = REWARD_NONE;
    if (in_exec < low_nxt) begin
      low_nxt    = in_exec;
      reward_nxt = REWARD_GOOD;
    end
    if ((in_exec > low_nxt) && (in_exec < high_nxt)) begin
      low_nxt    = in_exec;
      reward_nxt = REWARD_NONE;
    end
    if (in_exec > high_nxt) begin
      high_nxt   = in_exec;
      reward_nxt = REWARD_BAD;
    end
  end

  assign ram_raddr = ADDR_W'(row_r * NUM_ACTIONS) + ADDR_W'(j_r[ACT_W-1:0]);
  assign ram_waddr = ADDR_W'(row_r * NUM_ACTIONS) + ADDR_W'(action_r);
  assign rd_q      = rd_valid_r ? $signed(ram_rdata) : '0;
  assign out_free  = !out_valid_r || out_tready;
  assign ram_we    = (state_r == ST_WRITE) && out_free;

  assign upd_req.valid  = (state_r == ST_LAUNCH);
  assign upd_req.reward = reward_r;
  assign upd_req.qval   = explore_r ? qval_r : best_val_r;
  assign upd_req.qbest  = best_val_r;
  assign upd_req.gamma  = discount_r;
  assign upd_req.alpha  = learn_rate_r;

  tqls_ram #(
    .WIDTH (Q_W),
    .DEPTH (TABLE_DEPTH)
  ) u_qtab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (qnew_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tqls_update u_upd (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (upd_req),
    .rsp   (upd_rsp)
  );

  always_ff @(posedge clk) begin
    rd_valid_r <= tbl_valid_r[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      tbl_valid_r  <= '0;
      trial_r      <= '0;
      cur_r        <= '0;
      low_r        <= '1;
      high_r       <= '0;
      learn_rate_r <= LEARN_RATE_RST;
      discount_r   <= DISCOUNT_RST;
      init_low_r   <= '1;
      init_high_r  <= '0;
      pend_r       <= 1'b0;
      j_r          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LEARN_RATE: learn_rate_r <= cfg_wdata[RATE_W-1:0];
          CFG_DISCOUNT:   discount_r   <= cfg_wdata[RATE_W-1:0];
          CFG_INIT_LOW:   init_low_r   <= cfg_wdata[MARK_W-1:0];
          CFG_INIT_HIGH:  init_high_r  <= cfg_wdata[MARK_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            trial_r   <= trial_acc;
            if (explore) begin
              cur_r <= trial_acc;
            end
            low_r     <= low_nxt;
            high_r    <= high_nxt;
            reward_r  <= reward_nxt;
            row_r     <= row_acc;
            explore_r <= explore;
            action_r  <= t_act;
            j_r       <= '0;
            pend_r    <= 1'b0;
            state_r   <= ST_WALK;
          end
        end

        ST_WALK: begin
          if (j_r != J_W'(NUM_ACTIONS)) begin
            j_r <= j_r + 1'b1;
          end
          pend_r <= (j_r != J_W'(NUM_ACTIONS));
          pj_r   <= j_r[ACT_W-1:0];
          if (pend_r) begin
            // first strict maximum wins
            if ((pj_r == '0) || (rd_q > best_val_r)) begin
              best_val_r <= rd_q;
              best_idx_r <= pj_r;
            end
            if (explore_r && (pj_r == action_r)) begin
              qval_r <= rd_q;
            end
            if (pj_r == ACT_W'(NUM_ACTIONS - 1)) begin
              state_r <= ST_LAUNCH;
            end
          end
        end

        ST_LAUNCH: begin
          if (!explore_r) begin
            action_r <= best_idx_r;
          end
          if (best_idx_r != '0) begin
            cur_r <= STATE_W'(best_idx_r % NUM_STATES);
          end
          state_r <= ST_UPD;
        end

        ST_UPD: begin
          if (upd_rsp.valid) begin
            qnew_r  <= upd_rsp.qnew;
            state_r <= ST_WRITE;
          end
        end

        ST_WRITE: begin
          if (out_free) begin
            tbl_valid_r[ram_waddr] <= 1'b1;
            out_valid_r  <= 1'b1;
            out_action_r <= ACT_FIELD_W'(action_r);
            out_reward_r <= reward_r;
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_reward_r, out_action_r});

endmodule

`default_nettype wire

@@ rtl/tqls_checker.sv @@
`default_nettype none

module tqls_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [63:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_index,
  input wire logic [31:0] cfg_wdata
);

  logic unused_ok;
  assign unused_ok = ^{in_tdata, cfg_we, cfg_index, cfg_wdata};

  // one item in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_reward_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:3] == 3'b010) || (out_tdata[5:3] == 3'b000) ||
                   (out_tdata[5:3] == 3'b110))
    else $error("illegal reward code");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

endmodule

bind tabular_q_learner_step tqls_checker u_tqls_checker (.*);

`default_nettype wire

@@ verif/tabular_q_learner_step_test.sv @@
module tabular_q_learner_step_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tqls_pkg::*;

  typedef struct packed {
    logic [ACT_FIELD_W-1:0]     action;
    logic signed [REWARD_W-1:0] reward;
  } step_result_t;

  class q_learn_checker;
    int q_vals [TABLE_DEPTH];
    int unsigned trial_state;
    int unsigned cur_state;
    bit [MARK_W-1:0] low_mark, high_mark, init_low, init_high;
    bit [RATE_W-1:0] alpha, gamma;
    step_result_t pending_results[$];
    int errors, checked, n_good, n_none, n_bad;

    function new();
      foreach (q_vals[i]) q_vals[i] = 0;
      trial_state = 0;
      cur_state = 0;
      low_mark = '1;
      high_mark = '0;
      alpha = LEARN_RATE_RST;
      gamma = DISCOUNT_RST;
      init_low = '1;
      init_high = '0;
      errors = 0;
      checked = 0;
      n_good = 0;
      n_none = 0;
      n_bad = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, bit [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_LEARN_RATE: alpha = v[RATE_W-1:0];
        CFG_DISCOUNT:   gamma = v[RATE_W-1:0];
        CFG_INIT_LOW:   init_low = v[MARK_W-1:0];
        CFG_INIT_HIGH:  init_high = v[MARK_W-1:0];
        default: ;
      endcase
    endfunction

    // one learning step: action choice, reward from the marks, Q update
    function void take_step(bit [31:0] ts, bit [31:0] et);
      int unsigned act, row, best;
      logic signed [REWARD_W-1:0] rw;
      int qv, qb;
      longint d, nq;
      step_result_t res;
      if (ts < TABLE_DEPTH) begin
        if (ts % NUM_ACTIONS == 0) begin
          if (ts == 0) begin
            trial_state = 0;
            low_mark = init_low;
            high_mark = init_high;
          end else begin
            trial_state = (trial_state + 1) % NUM_STATES;
          end
        end
        cur_state = trial_state;
        act = ts % NUM_ACTIONS;
      end else begin
        row = cur_state % NUM_STATES;
        best = 0;
        for (int j = 1; j < NUM_ACTIONS; j++)
          if (q_vals[row*NUM_ACTIONS + j] > q_vals[row*NUM_ACTIONS + best]) best = j;
        act = best;
      end

      rw = REWARD_NONE;
      if (et < low_mark) begin
        low_mark = et;
        rw = REWARD_GOOD;
      end
      if (et > low_mark && et < high_mark) begin
        low_mark = et;
        rw = REWARD_NONE;
      end
      if (et > high_mark) begin
        high_mark = et;
        rw = REWARD_BAD;
      end

      // row walk also moves cur_state to any later strictly larger index
      row = cur_state % NUM_STATES;
      qv = q_vals[row*NUM_ACTIONS + act];
      qb = q_vals[row*NUM_ACTIONS];
      for (int j = 1; j < NUM_ACTIONS; j++) begin
        if (q_vals[row*NUM_ACTIONS + j] > qb) begin
          qb = q_vals[row*NUM_ACTIONS + j];
          cur_state = j % NUM_STATES;
        end
      end

      d = longint'(rw) * 65536 + ((longint'(gamma) * longint'(qb)) >>> FRAC_W)
          - longint'(qv);
      d = (longint'(alpha) * d) >>> FRAC_W;
      nq = longint'(qv) + d;
      if (nq > longint'(32'sh7FFF_FFFF)) nq = longint'(32'sh7FFF_FFFF);
      else if (nq < longint'(32'sh8000_0000)) nq = longint'(32'sh8000_0000);
      q_vals[row*NUM_ACTIONS + act] = int'(nq);

      res.action = act[ACT_FIELD_W-1:0];
      res.reward = rw;
      pending_results.push_back(res);
      if (rw == REWARD_GOOD) n_good++;
      else if (rw == REWARD_BAD) n_bad++;
      else n_none++;
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      step_result_t want;
      logic [ACT_FIELD_W-1:0] got_act;
      logic signed [REWARD_W-1:0] got_rw;
      got_act = d[ACT_FIELD_W-1:0];
      got_rw = d[ACT_FIELD_W +: REWARD_W];
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: unexpected result, expected none, actual action %0d reward %0d",
                   $time, got_act, got_rw);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got_act !== want.action) begin
        errors++;
        if (errors <= 100)
          $display("%0t: chosen_action mismatch, expected %0d, actual %0d",
                   $time, want.action, got_act);
      end
      if (got_rw !== want.reward) begin
        errors++;
        if (errors <= 100)
          $display("%0t: reward_code mismatch, expected %0d, actual %0d",
                   $time, want.reward, got_rw);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LEARN_RATE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  q_learn_checker sb;
  int items_sent = 0;
  int burst_left = 0;
  bit idle_on = 1'b1;
  int settings_used = 1;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;

  tabular_q_learner_step uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: check, then pick next ready from the stall pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    rx_cycle++;
    if (rx_cycle % 200 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left == 0 && hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (rx_cycle % 7) < 3;
      endcase
    end
  end

  task automatic drive_item(bit [31:0] ts, bit [31:0] et);
    if (idle_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {et, ts};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_step(ts, et);
    items_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, bit [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic set_regs(bit [15:0] lr, bit [15:0] dc, bit [31:0] lo, bit [31:0] hi);
    drain();
    put_reg(CFG_LEARN_RATE, {16'h0, lr});
    put_reg(CFG_DISCOUNT, {16'h0, dc});
    put_reg(CFG_INIT_LOW, lo);
    put_reg(CFG_INIT_HIGH, hi);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // exec times aimed at and around the running marks
  function automatic bit [31:0] pick_exec();
    bit [31:0] lo, hi, v;
    lo = sb.low_mark;
    hi = sb.high_mark;
    case ($urandom_range(0, 7))
      0: v = $urandom();
      1: v = (lo > 16) ? lo - $urandom_range(1, 16) : $urandom_range(0, lo);
      2: v = lo;
      3: v = (hi < 32'hFFFF_FFF0) ? hi + $urandom_range(1, 16)
                                  : $urandom_range(hi, 32'hFFFF_FFFF);
      4: v = hi;
      5: v = (lo != '1 && hi > lo + 1) ? lo + 1 + ($urandom() % (hi - lo - 1)) : $urandom();
      6: v = $urandom_range(0, 255);
      default: v = {24'hFF_FFFF, 8'($urandom())};
    endcase
    return v;
  endfunction

  // episodes from timestep zero through exploitation, with some noise
  task automatic run_phase(int n_items);
    int unsigned t, ep_len, stop_at, r;
    bit [31:0] ts;
    t = 0;
    ep_len = TABLE_DEPTH + $urandom_range(0, 80);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        drive_item($urandom(), pick_exec());
      end else if (r < 8) begin
        drive_item(NUM_ACTIONS * $urandom_range(1, NUM_STATES - 1), pick_exec());
      end else begin
        if (r < 11) t += $urandom_range(1, 5);
        if (t >= ep_len) begin
          t = 0;
          ep_len = TABLE_DEPTH + $urandom_range(0, 80);
        end
        ts = t;
        if (t >= TABLE_DEPTH && $urandom_range(0, 4) == 0)
          ts = $urandom_range(32'hFFFF_FFFF, TABLE_DEPTH);
        drive_item(ts, pick_exec());
        t++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // marks from reset defaults, each reward path, equal-to-mark cases
    drive_item(0, 32'h0000_0000);
    drive_item(1, 32'hFFFF_FFFF);
    drive_item(2, 32'hFFFF_FFFF);
    drive_item(3, 32'h8000_0000);
    drive_item(4, 32'h8000_0000);
    drive_item(5, 32'h7FFF_FFFF);
    drive_item(6, 32'h0000_0000);
    drive_item(7, 32'h0000_0000);
    drive_item(8, 32'h1234_5678);
    drive_item(15, 32'hFFFF_FFFF);
    drive_item(16, 32'h0000_0001);
    drive_item(63, 32'hAAAA_AAAA);
    drive_item(64, 32'h5555_5555);
    drive_item(65, 32'h0000_0000);
    drive_item(32'hFFFF_FFFF, 32'h0000_0001);
    drive_item(32'h8000_0000, 32'hFFFF_FFFF);
    // out-of-order timesteps step the trial state on at each row start; timestep zero resets it
    drive_item(8, 32'h0001_0000);
    drive_item(8, 32'h0002_0000);
    drive_item(56, 32'hFFFF_0000);
    drive_item(0, 32'h0000_0005);

    run_phase(120);
    hold_asked++;
    run_phase(100);
    drain();

    set_regs(16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFF_FFFF);
    idle_on = 1'b0;
    run_phase(220);

    set_regs(16'h0, 16'h0, 32'hFFFF_FFFF, 32'h0);
    idle_on = 1'b1;
    run_phase(100);
    hold_asked++;
    run_phase(100);

    set_regs(16'($urandom()), 16'($urandom()), $urandom(), $urandom());
    run_phase(250);

    set_regs(16'h8000, 16'hFFFF, $urandom(), $urandom_range(0, 32'h00FF_FFFF));
    run_phase(250);

    drain();
    $display("Ran %0d learning steps over %0d register settings, %0d results checked",
             items_sent, settings_used, sb.checked);
    $display("Rewards seen: %0d good, %0d neutral, %0d bad",
             sb.n_good, sb.n_none, sb.n_bad);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ tabular_q_learner_step.f @@
rtl/tqls_pkg.sv
rtl/tqls_ram.sv
rtl/tqls_update.sv
rtl/tabular_q_learner_step.sv
rtl/tqls_checker.sv
verif/tabular_q_learner_step_test.sv
